FILE: src/drf_pkg.sv
// ----------------------------------------------------------------------------
// drf_pkg: shared types and constants of the regression delta filter
// Holds the control register codes, register reset values, the fixed
// fraction width of the scale and the datapath control group.
// ----------------------------------------------------------------------------
`default_nettype none

package drf_pkg;

   localparam int WIN_BITS      = 4;
   localparam int SCALE_BITS    = 16;
   localparam int FRAC_BITS     = 16;
   localparam int CSR_IDX_BITS  = 1;
   localparam int CSR_DATA_BITS = 16;

   localparam logic [WIN_BITS-1:0]   WINDOW_RESET = 4'd2;
   localparam logic [SCALE_BITS-1:0] SCALE_RESET  = 16'd6554;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_WINDOW = 1'b0,
      CSR_SCALE  = 1'b1
   } csr_idx_type;

   // Control from the sequencer to the multiply-accumulate datapath.
   typedef struct packed {
      logic acc_clr;   // start a new tap sum
      logic acc_en;    // add the tap whose history words have just been read
      logic past_mem;  // past tap comes from the history, else the first sample
      logic mul_en;    // multiply the finished sum by the scale
   } dp_ctrl_type;

endpackage

`default_nettype wire

FILE: src/drf_hist_mem.sv
// ----------------------------------------------------------------------------
// drf_hist_mem: sample history store
// Circular store of the most recent samples, one write port and two read
// ports with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module drf_hist_mem #(
   parameter int DEPTH      = 17,
   parameter int WIDTH      = 16,
   parameter int ADDR_BITS  = 5
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]     wr_data,
   input  wire logic                 rd_en,
   input  wire logic [ADDR_BITS-1:0] rd_addr_a,
   input  wire logic [ADDR_BITS-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]     rd_data_a,
   output logic      [WIDTH-1:0]     rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

`default_nettype wire

FILE: src/drf_datapath.sv
// ----------------------------------------------------------------------------
// drf_datapath: shared multiply-accumulate and output scaling
// Accumulates weighted tap differences one tap per cycle, multiplies the sum
// by the scale, then rounds to nearest and saturates to the sample width.
// ----------------------------------------------------------------------------
`default_nettype none

module drf_datapath
   import drf_pkg::*;
#(
   parameter int SAMPLE_BITS = 16,
   parameter int WT_BITS     = 4,
   parameter int ACC_BITS    = 25
) (
   input  wire logic                          clock,
   input  wire dp_ctrl_type                   ctrl,
   input  wire logic        [WT_BITS-1:0]     wt,
   input  wire logic signed [SAMPLE_BITS-1:0] fut,
   input  wire logic signed [SAMPLE_BITS-1:0] past,
   input  wire logic signed [SAMPLE_BITS-1:0] first,
   input  wire logic        [SCALE_BITS-1:0]  scale,
   output logic signed      [SAMPLE_BITS-1:0] delta
);

   localparam int DIFF_BITS = SAMPLE_BITS + 1;
   localparam int TERM_BITS = DIFF_BITS + WT_BITS + 1;
   localparam int PROD_BITS = ACC_BITS + SCALE_BITS + 1;
   localparam int Q_BITS    = PROD_BITS - FRAC_BITS;

   localparam logic signed [PROD_BITS-1:0] ROUND_HALF =
      PROD_BITS'(64'sd1 <<< (FRAC_BITS - 1));
   localparam logic signed [Q_BITS-1:0] Q_MAX =
      Q_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
   localparam logic signed [Q_BITS-1:0] Q_MIN = -Q_MAX - Q_BITS'(1);

   logic signed [DIFF_BITS-1:0] diff;
   logic signed [TERM_BITS-1:0] term;
   logic signed [ACC_BITS-1:0]  acc_ff;
   logic signed [ACC_BITS-1:0]  acc_in;
   logic signed [PROD_BITS-1:0] prod_ff;
   logic signed [PROD_BITS-1:0] rnd;
   logic signed [Q_BITS-1:0]    quot;

   always_comb begin
      if (ctrl.past_mem) begin
         diff = DIFF_BITS'(fut) - DIFF_BITS'(past);
      end else begin
         diff = DIFF_BITS'(fut) - DIFF_BITS'(first);
      end
      term = TERM_BITS'(diff) * TERM_BITS'($signed({1'b0, wt}));
      if (ctrl.acc_clr) begin
         acc_in = '0;
      end else if (ctrl.acc_en) begin
         acc_in = acc_ff + ACC_BITS'(term);
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (ctrl.mul_en) begin
         prod_ff <= PROD_BITS'(acc_ff) * PROD_BITS'($signed({1'b0, scale}));
      end
   end

   // The arithmetic shift floors, so adding one half first rounds ties upwards.
   always_comb begin
      rnd  = prod_ff + ROUND_HALF;
      quot = $signed(rnd[PROD_BITS-1:FRAC_BITS]);
      if (quot > Q_MAX) begin
         delta = Q_MAX[SAMPLE_BITS-1:0];
      end else if (quot < Q_MIN) begin
         delta = Q_MIN[SAMPLE_BITS-1:0];
      end else begin
         delta = quot[SAMPLE_BITS-1:0];
      end
   end

endmodule

`default_nettype wire

FILE: src/delta_regression_filter.sv
// Each result passes through the check, one history read per tap, the drain, the multiply
// and the round steps. A new sample is taken only in the idle state, so requests stall
// until every result that the last sample released has been given; the single
// multiply-accumulate is shared by all of them.
// Reset is synchronous and clears the sequence state and the output valid;
// window returns to 2 and scale to 6554. The history store is not cleared.
// ----------------------------------------------------------------------------
// delta_regression_filter: streaming regression delta coefficients
// Keeps a history of recent samples and, per sample, gives the scaled
// weighted sum of differences of its neighbours, clamped at sequence edges.
// ----------------------------------------------------------------------------
`default_nettype none

module delta_regression_filter
   import drf_pkg::*;
#(
   parameter int MAX_WIN     = 8,
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic signed [SAMPLE_BITS-1:0] req_sample,
   input  wire logic                          req_last,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic signed      [SAMPLE_BITS-1:0] rsp_orig_sample,
   output logic signed      [SAMPLE_BITS-1:0] rsp_delta,
   output logic                               rsp_last_res,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic        [CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic        [CSR_DATA_BITS-1:0] csr_wdata
);

   localparam int HIST_LEN  = 2 * MAX_WIN + 1;
   localparam int IDX_BITS  = $clog2(HIST_LEN);
   localparam int SEEN_BITS = $clog2(HIST_LEN + 1);
   localparam int PEND_BITS = $clog2(MAX_WIN + 2);
   localparam int WT_BITS   = $clog2(MAX_WIN + 1);
   localparam int ACC_BITS  = SAMPLE_BITS + 1 + 2 * WT_BITS;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_TAP,
      ST_DRAIN,
      ST_MUL,
      ST_ROUND
   } state_type;

   state_type                      state_ff, state_in;
   logic [WIN_BITS-1:0]            window_ff, window_in;
   logic [SCALE_BITS-1:0]          scale_ff, scale_in;
   logic [IDX_BITS-1:0]            newest_ff, newest_in;
   logic [SEEN_BITS-1:0]           seen_ff, seen_in;
   logic [PEND_BITS-1:0]           pending_ff, pending_in;
   logic signed [SAMPLE_BITS-1:0]  first_ff, first_in;
   logic                           last_ff, last_in;
   logic [WT_BITS-1:0]             n_ff, n_in;
   logic [WT_BITS-1:0]             wt_ff, wt_in;
   logic                           rd_vld_ff, rd_vld_in;
   logic                           past_mem_ff, past_mem_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0]  orig_ff, orig_in;
   logic signed [SAMPLE_BITS-1:0]  delta_ff, delta_in;
   logic                           last_res_ff, last_res_in;

   logic [WT_BITS-1:0]             w_eff;
   logic [IDX_BITS-1:0]            newest_next;
   logic [IDX_BITS-1:0]            cur_idx;
   logic [IDX_BITS:0]              fut_off;
   logic [IDX_BITS:0]              past_off;
   logic                           past_ok;
   logic                           emit;
   logic                           wr_en;
   logic                           rd_en;
   logic [IDX_BITS-1:0]            rd_addr_a;
   logic [IDX_BITS-1:0]            rd_addr_b;
   logic [SAMPLE_BITS-1:0]         rd_data_a;
   logic [SAMPLE_BITS-1:0]         rd_data_b;
   dp_ctrl_type                    dp_ctrl;
   logic signed [SAMPLE_BITS-1:0]  dp_delta;

   // Store address of the sample that lies off places back from the newest.
   function automatic logic [IDX_BITS-1:0] hist_addr(
      input logic [IDX_BITS-1:0] top_i,
      input logic [IDX_BITS:0]   off
   );
      logic [IDX_BITS:0] t;
      t = {1'b0, top_i};
      if (t >= off) begin
         return IDX_BITS'(t - off);
      end
      return IDX_BITS'(t + (IDX_BITS + 1)'(HIST_LEN) - off);
   endfunction

   always_comb begin
      if (window_ff == '0) begin
         w_eff = WT_BITS'(1);
      end else if (int'(window_ff) > MAX_WIN) begin
         w_eff = WT_BITS'(MAX_WIN);
      end else begin
         w_eff = WT_BITS'(window_ff);
      end
   end

   assign newest_next = (newest_ff == IDX_BITS'(HIST_LEN - 1)) ? '0
                                                               : newest_ff + 1'b1;
   assign cur_idx  = IDX_BITS'(pending_ff - PEND_BITS'(1));
   assign fut_off  = ({1'b0, cur_idx} >= (IDX_BITS + 1)'(n_ff))
                     ? {1'b0, cur_idx} - (IDX_BITS + 1)'(n_ff) : '0;
   assign past_off = {1'b0, cur_idx} + (IDX_BITS + 1)'(n_ff);
   assign past_ok  = ((IDX_BITS + 1)'(past_off) < (IDX_BITS + 1)'(seen_ff))
                     && (past_off < (IDX_BITS + 1)'(HIST_LEN));
   assign emit     = (pending_ff > PEND_BITS'(w_eff))
                     || (last_ff && (pending_ff != '0));

   always_comb begin
      rd_en     = (state_ff == ST_TAP) || (state_ff == ST_DRAIN);
      rd_addr_a = hist_addr(newest_ff, fut_off);
      rd_addr_b = hist_addr(newest_ff, past_off);
      if (state_ff == ST_DRAIN) begin
         rd_addr_a = hist_addr(newest_ff, {1'b0, cur_idx});
      end
   end

   always_comb begin
      state_in     = state_ff;
      window_in    = window_ff;
      scale_in     = scale_ff;
      newest_in    = newest_ff;
      seen_in      = seen_ff;
      pending_in   = pending_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      n_in         = n_ff;
      wt_in        = wt_ff;
      rd_vld_in    = 1'b0;
      past_mem_in  = past_mem_ff;
      rsp_valid_in = rsp_valid_ff;
      orig_in      = orig_ff;
      delta_in     = delta_ff;
      last_res_in  = last_res_ff;
      wr_en        = 1'b0;
      dp_ctrl.acc_clr  = 1'b0;
      dp_ctrl.acc_en   = rd_vld_ff;
      dp_ctrl.past_mem = past_mem_ff;
      dp_ctrl.mul_en   = 1'b0;

      if (csr_valid) begin
         case (csr_idx_type'(csr_index))
            CSR_WINDOW: window_in = csr_wdata[WIN_BITS-1:0];
            CSR_SCALE:  scale_in  = csr_wdata[SCALE_BITS-1:0];
            default:    ;
         endcase
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               wr_en     = 1'b1;
               newest_in = newest_next;
               if (seen_ff == '0) begin
                  first_in = req_sample;
               end
               if (seen_ff != SEEN_BITS'(HIST_LEN)) begin
                  seen_in = seen_ff + 1'b1;
               end
               pending_in = pending_ff + 1'b1;
               last_in    = req_last;
               state_in   = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (emit) begin
               dp_ctrl.acc_clr = 1'b1;
               n_in            = WT_BITS'(1);
               state_in        = ST_TAP;
            end else begin
               if (last_ff) begin
                  seen_in    = '0;
                  pending_in = '0;
                  last_in    = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
         ST_TAP: begin
            rd_vld_in   = 1'b1;
            wt_in       = n_ff;
            past_mem_in = past_ok;
            n_in        = n_ff + 1'b1;
            if (n_ff == w_eff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            dp_ctrl.mul_en = 1'b1;
            state_in       = ST_ROUND;
         end
         ST_ROUND: begin
            // The sample itself was read during the drain cycle.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               orig_in      = $signed(rd_data_a);
               delta_in     = dp_delta;
               last_res_in  = last_ff && (pending_ff == PEND_BITS'(1));
               pending_in   = pending_ff - 1'b1;
               state_in     = ST_CHECK;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         window_ff    <= WINDOW_RESET;
         scale_ff     <= SCALE_RESET;
         newest_ff    <= '0;
         seen_ff      <= '0;
         pending_ff   <= '0;
         first_ff     <= '0;
         last_ff      <= 1'b0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         window_ff    <= window_in;
         scale_ff     <= scale_in;
         newest_ff    <= newest_in;
         seen_ff      <= seen_in;
         pending_ff   <= pending_in;
         first_ff     <= first_in;
         last_ff      <= last_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff        <= n_in;
      wt_ff       <= wt_in;
      past_mem_ff <= past_mem_in;
      orig_ff     <= orig_in;
      delta_ff    <= delta_in;
      last_res_ff <= last_res_in;
   end

   drf_hist_mem #(
      .DEPTH     (HIST_LEN),
      .WIDTH     (SAMPLE_BITS),
      .ADDR_BITS (IDX_BITS)
   ) u_hist (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (newest_next),
      .wr_data   (req_sample),
      .rd_en     (rd_en),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   drf_datapath #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .WT_BITS     (WT_BITS),
      .ACC_BITS    (ACC_BITS)
   ) u_dp (
      .clock (clock),
      .ctrl  (dp_ctrl),
      .wt    (wt_ff),
      .fut   ($signed(rd_data_a)),
      .past  ($signed(rd_data_b)),
      .first (first_ff),
      .scale (scale_ff),
      .delta (dp_delta)
   );

   assign req_stall       = (state_ff != ST_IDLE);
   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_orig_sample = orig_ff;
   assign rsp_delta       = delta_ff;
   assign rsp_last_res    = last_res_ff;

   // Never more samples awaiting their delta than the widest window plus one.
   assert property (@(posedge clock) disable iff (reset)
      pending_ff <= PEND_BITS'(MAX_WIN + 1))
      else $error("pending count above its bound");

   // Pending samples are always a subset of those held in the history.
   assert property (@(posedge clock) disable iff (reset)
      SEEN_BITS'(pending_ff) <= seen_ff)
      else $error("pending count exceeds samples held");

   // A final sample is fully flushed before the next transaction is taken.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !last_ff)
      else $error("idle with an unfinished final sample");

   // An accepted transaction is always followed by a check of pending work.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_CHECK))
      else $error("accepted sample not checked for results");

endmodule

`default_nettype wire

FILE: test/delta_ledger_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delta_ledger_pkg: expected-result bookkeeping for the delta filter bench
// Tracks the filter's sequence state and configuration alongside the block.
// It works out the deltas that each accepted sample releases and checks every
// delivered result against the oldest delta still owed.
// ----------------------------------------------------------------------------
package delta_ledger_pkg;

   import drf_pkg::*;

   localparam int MAX_WIN     = 8;
   localparam int SAMPLE_BITS = 16;
   localparam int HIST_LEN    = 2 * MAX_WIN + 1;
   localparam longint SAT_HI  = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
   localparam longint SAT_LO  = -SAT_HI - 1;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   typedef struct {
      sample_type orig;
      sample_type delta;
      logic       last;
   } delta_rec_type;

   class delta_ledger;
      logic [WIN_BITS-1:0]   window;
      logic [SCALE_BITS-1:0] scale;
      sample_type            hist[HIST_LEN];   // newest sample at index 0
      sample_type            first;
      int                    seen;
      int                    emitted;
      delta_rec_type         owed[$];
      int                    errors;

      function new();
         window  = WINDOW_RESET;
         scale   = SCALE_RESET;
         foreach (hist[i]) hist[i] = '0;
         first   = '0;
         seen    = 0;
         emitted = 0;
         errors  = 0;
      endfunction

      function void write_reg(csr_idx_type idx, logic [CSR_DATA_BITS-1:0] data);
         case (idx)
            CSR_WINDOW: window = data[WIN_BITS-1:0];
            CSR_SCALE:  scale  = data[SCALE_BITS-1:0];
            default: ;
         endcase
      endfunction

      function int waiting();
         return owed.size();
      endfunction

      // Works out the delta of the oldest sample still pending.
      function void owe_delta(int w, logic is_last);
         int            c;
         longint        acc;
         longint        fut;
         longint        past;
         longint        d;
         delta_rec_type rec;
         c   = seen - emitted - 1;
         acc = 0;
         for (int n = 1; n <= w; n++) begin
            fut  = (c >= n) ? hist[(c - n) % HIST_LEN] : hist[0];
            past = (c + n < seen && c + n < HIST_LEN) ? hist[c + n] : first;
            acc += n * (fut - past);
         end
         // Arithmetic shift floors, so adding half first rounds ties upwards.
         d = (acc * longint'(scale) + 32768) >>> 16;
         if (d > SAT_HI) d = SAT_HI;
         if (d < SAT_LO) d = SAT_LO;
         rec.orig  = hist[c % HIST_LEN];
         rec.delta = d[SAMPLE_BITS-1:0];
         rec.last  = is_last;
         owed.push_back(rec);
         emitted++;
      endfunction

      function void take_sample(sample_type s, logic last_in);
         int w;
         w = int'(window);
         if (w < 1) w = 1;
         if (w > MAX_WIN) w = MAX_WIN;
         if (seen == 0) first = s;
         for (int i = HIST_LEN - 1; i > 0; i--) hist[i] = hist[i-1];
         hist[0] = s;
         seen++;
         if (seen > HIST_LEN) begin
            seen = HIST_LEN;
            emitted--;
         end
         while (seen - emitted > w) owe_delta(w, last_in && (seen - emitted == 1));
         if (last_in) begin
            while (seen - emitted > 0) owe_delta(w, seen - emitted == 1);
            seen    = 0;
            emitted = 0;
         end
      endfunction

      function void check_delta(sample_type orig, sample_type delta, logic last);
         delta_rec_type want;
         if (owed.size() == 0) begin
            errors++;
            $display("%0t: result with nothing owed: orig %0d delta %0d last %0b",
                     $time, orig, delta, last);
            return;
         end
         want = owed.pop_front();
         if (want.orig !== orig) begin
            errors++;
            $display("%0t: orig_sample mismatch: expected %0d, got %0d",
                     $time, want.orig, orig);
         end
         if (want.delta !== delta) begin
            errors++;
            $display("%0t: delta mismatch: expected %0d, got %0d",
                     $time, want.delta, delta);
         end
         if (want.last !== last) begin
            errors++;
            $display("%0t: last_res mismatch: expected %0b, got %0b",
                     $time, want.last, last);
         end
      endfunction
   endclass

endpackage

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: bench for the regression delta filter
// Streams directed and random feature sequences through the filter under
// varying window and scale settings and back-pressure, checking every delta
// against the ledger's own prediction in order.
// ----------------------------------------------------------------------------
module tb;

   import drf_pkg::*;
   import delta_ledger_pkg::*;

   localparam int SETTLE_CYCLES = 40;

   logic                       clock         = 1'b0;
   logic                       reset         = 1'b1;
   logic                       req_valid     = 1'b0;
   logic                       req_stall;
   sample_type                 req_sample    = '0;
   logic                       req_last      = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_stall     = 1'b0;
   sample_type                 rsp_orig_sample;
   sample_type                 rsp_delta;
   logic                       rsp_last_res;
   logic                       csr_valid     = 1'b0;
   logic                       csr_ready;
   logic [CSR_IDX_BITS-1:0]    csr_index     = '0;
   logic [CSR_DATA_BITS-1:0]   csr_wdata     = '0;

   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   delta_ledger ledger;

   delta_regression_filter dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_sample      (req_sample),
      .req_last        (req_last),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_orig_sample (rsp_orig_sample),
      .rsp_delta       (rsp_delta),
      .rsp_last_res    (rsp_last_res),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall)
         ledger.check_delta(rsp_orig_sample, rsp_delta, rsp_last_res);
   end

   // Offers one sample and returns just after the falling edge that follows
   // its transaction, leaving valid high for a following sample.
   task automatic send_sample(sample_type s, logic lst);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= s;
      req_last   <= lst;
      do @(posedge clock); while (req_stall);
      ledger.take_sample(s, lst);
      @(negedge clock);
   endtask

   task automatic write_reg(csr_idx_type idx, logic [CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      ledger.write_reg(idx, data);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // Holds the sender off until every owed delta has arrived, then lets the
   // block finish any sample that released nothing.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (ledger.waiting() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic random_config();
      logic [WIN_BITS-1:0]      w;
      int                       eff;
      logic [SCALE_BITS-1:0]    sc;
      logic [CSR_DATA_BITS-1:0] wd;
      w   = WIN_BITS'($urandom_range(15));
      eff = (w == 0) ? 1 : ((int'(w) > MAX_WIN) ? MAX_WIN : int'(w));
      case ($urandom_range(3))
         0, 1: sc = SCALE_BITS'(32768 / (eff * (eff + 1) * (2 * eff + 1) / 6));
         2: sc = SCALE_BITS'($urandom_range(65535));
         default: sc = $urandom_range(1) ? '0 : '1;
      endcase
      // Bits above the window field are noise that the block must ignore.
      wd = CSR_DATA_BITS'($urandom);
      wd[WIN_BITS-1:0] = w;
      write_reg(CSR_WINDOW, wd);
      write_reg(CSR_SCALE, sc);
   endtask

   function automatic sample_type next_sample(sample_type prev);
      sample_type s;
      case ($urandom_range(7))
         0: s = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
         1, 2, 3: s = sample_type'($urandom);
         default: s = prev + sample_type'($urandom_range(1023)) - 16'sd512;
      endcase
      return s;
   endfunction

   // Sequences are mostly long enough to fill the window; some stay open
   // across a reconfiguration so that the window changes mid-sequence.
   task automatic run_phase(int items, int s_pct, int r_pct);
      int         sent;
      int         len;
      logic       lst;
      sample_type s;
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      random_config();
      sent = 0;
      s    = '0;
      while (sent < items) begin
         len = ($urandom_range(3) == 0) ? int'($urandom_range(1, 4))
                                        : int'($urandom_range(5, 24));
         for (int i = 0; i < len && sent < items; i++) begin
            s   = next_sample(s);
            lst = (i == len - 1) && ($urandom_range(4) != 0);
            send_sample(s, lst);
            sent++;
            if (sent == items / 2) begin
               wait_drained();
               random_config();
            end
         end
      end
      wait_drained();
   endtask

   initial begin
      ledger = new();
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      send_idle_pct = 16;
      recv_idle_pct = 85;

      // Reset settings: a one-sample sequence, then a two-sample one.
      send_sample(16'sh7FFF, 1'b1);
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sh7FFF, 1'b1);
      wait_drained();

      // A zero window behaves as one; full scale drives saturation.
      write_reg(CSR_WINDOW, 16'hFFF0);
      write_reg(CSR_SCALE, 16'hFFFF);
      send_sample(16'sh7FFF, 1'b0);
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sh0000, 1'b1);
      wait_drained();

      // An oversized window behaves as the largest one.
      write_reg(CSR_WINDOW, 16'h000F);
      write_reg(CSR_SCALE, 16'h8000);
      for (int i = 0; i < 10; i++)
         send_sample((i % 3 == 0) ? 16'sh8000 : sample_type'(i * 3000), 1'b0);
      wait_drained();

      // Narrowing the window mid-sequence releases everything beyond it at
      // once, and the sequence grows past the history depth.
      write_reg(CSR_WINDOW, 16'h0001);
      for (int i = 0; i < 8; i++)
         send_sample(sample_type'(7 - i * 4000), i == 7);
      wait_drained();

      write_reg(CSR_SCALE, 16'h0000);
      send_sample(16'sh1234, 1'b1);
      wait_drained();

      run_phase(78, 16, 85);
      run_phase(78, 85, 16);
      run_phase(78, 0, 0);

      if (ledger.errors == 0 && ledger.waiting() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
